>>> rtl/mqws_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Work-stealing queue package
// Shared types, register indexes, operation codes and reset values.
// ----------------------------------------------------------------------------
package mqws_pkg;

  localparam int NUM_QUEUES_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int MAX_QUEUES      = 4;
  localparam int PAYLOAD_BITS    = 32;
  localparam int QIDX_BITS       = 2;
  localparam int TOTAL_BITS      = 9;
  localparam int ACTIVE_BITS     = 3;
  localparam int ORDER_BITS      = 6;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 6;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_ACTIVE = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ORDER0 = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ORDER1 = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ORDER2 = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ORDER3 = 3'd4;

  localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 3'd4;
  localparam logic [ORDER_BITS-1:0]  ORDER0_RESET = 6'd57;
  localparam logic [ORDER_BITS-1:0]  ORDER1_RESET = 6'd14;
  localparam logic [ORDER_BITS-1:0]  ORDER2_RESET = 6'd19;
  localparam logic [ORDER_BITS-1:0]  ORDER3_RESET = 6'd36;

  typedef enum logic [1:0] {
    FUNC_ENQ    = 2'd0,
    FUNC_STEAL  = 2'd1,
    FUNC_LOCAL  = 2'd2,
    FUNC_REMOTE = 2'd3
  } func_t;

  typedef struct packed {
    logic load_req;
    logic exec;
    logic load_out;
  } mqws_cmd_t;

endpackage
`default_nettype wire

>>> rtl/mqws_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mqws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire                     re,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/mqws_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Work-stealing queue controller
// Sequences accept, queue update and result load, and owns the output valid.
// ----------------------------------------------------------------------------
module mqws_ctrl
  import mqws_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  wire        out_stall,
  output mqws_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_WRAP = 3'b100
  } state_t;

  state_t state, state_next;
  logic   can_load;
  logic   accept;

  assign can_load = !out_valid || !out_stall;

  always_comb begin
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_WRAP: in_stall = !can_load;
      default: in_stall = 1'b1;
    endcase
  end

  assign accept       = in_valid && !in_stall;
  assign cmd.load_req = accept;
  assign cmd.exec     = (state == ST_EXEC);
  assign cmd.load_out = (state == ST_WRAP) && can_load;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: state_next = ST_WRAP;
      ST_WRAP: begin
        if (can_load) state_next = accept ? ST_EXEC : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/mqws_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Work-stealing queue datapath
// Queue pointers, fill levels, configuration, queue selection, item store
// and result register.
// ----------------------------------------------------------------------------
module mqws_dp
  import mqws_pkg::*;
#(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire mqws_cmd_t            cmd,
  input  wire [1:0]                 func,
  input  wire [QIDX_BITS-1:0]       home_queue,
  input  wire [QIDX_BITS-1:0]       target_queue,
  input  wire [PAYLOAD_BITS-1:0]    payload_in,
  input  wire                       cfg_valid,
  input  wire [CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire [CFG_DATA_BITS-1:0]   cfg_data,
  output logic                      found,
  output logic [PAYLOAD_BITS-1:0]   payload_out,
  output logic [QIDX_BITS-1:0]      source_queue,
  output logic                      overflow,
  output logic [TOTAL_BITS-1:0]     total_items
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_D  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(MEM_D);

  logic [PTR_W-1:0]        read_pointer  [MAX_QUEUES];
  logic [PTR_W-1:0]        write_pointer [MAX_QUEUES];
  logic [FILL_W-1:0]       fill_level    [MAX_QUEUES];
  logic [ACTIVE_BITS-1:0]  active_queues;
  logic [ORDER_BITS-1:0]   steal_order   [MAX_QUEUES];

  func_t                   req_func;
  logic [QIDX_BITS-1:0]    req_home;
  logic [QIDX_BITS-1:0]    req_target;
  logic [PAYLOAD_BITS-1:0] req_payload;

  logic                    res_hit;
  logic [QIDX_BITS-1:0]    res_src;
  logic                    res_ovf;

  logic [ACTIVE_BITS-1:0]  active_limit;
  logic [MAX_QUEUES-1:0]   q_active;
  logic [MAX_QUEUES-1:0]   q_avail;
  logic                    hit;
  logic [QIDX_BITS-1:0]    sel;
  logic                    enq_ok;
  logic                    do_enq;
  logic                    do_deq;
  logic [ADDR_W-1:0]       waddr;
  logic [ADDR_W-1:0]       raddr;
  logic [PAYLOAD_BITS-1:0] rdata;
  logic [TOTAL_BITS-1:0]   total;

  assign active_limit = (active_queues > ACTIVE_BITS'(NUM_QUEUES)) ?
                        ACTIVE_BITS'(NUM_QUEUES) : active_queues;

  always_comb begin
    for (int q = 0; q < MAX_QUEUES; q++) begin
      q_active[q] = ACTIVE_BITS'(q) < active_limit;
      q_avail[q]  = q_active[q] && (fill_level[q] != '0);
    end
  end

  always_comb begin
    logic [ORDER_BITS-1:0] order;
    logic [QIDX_BITS-1:0]  cand [MAX_QUEUES];
    logic [MAX_QUEUES-1:0] cand_en;
    order = steal_order[req_home];
    cand[0] = req_home;
    cand[1] = order[1:0];
    cand[2] = order[3:2];
    cand[3] = order[5:4];
    cand_en = '0;
    case (req_func)
      FUNC_STEAL: cand_en = 4'b1111;
      FUNC_REMOTE: begin
        cand[0] = order[1:0];
        cand[1] = order[3:2];
        cand[2] = order[5:4];
        cand[3] = req_home;
        cand_en = 4'b1111;
      end
      FUNC_LOCAL: cand_en = 4'b0001;
      default: cand_en = 4'b0000;
    endcase
    hit = 1'b0;
    sel = '0;
    for (int k = MAX_QUEUES - 1; k >= 0; k--) begin
      if (cand_en[k] && q_avail[cand[k]]) begin
        hit = 1'b1;
        sel = cand[k];
      end
    end
  end

  assign enq_ok = q_active[req_target] && (fill_level[req_target] != FILL_W'(QUEUE_DEPTH));
  assign do_enq = cmd.exec && (req_func == FUNC_ENQ) && enq_ok;
  assign do_deq = cmd.exec && (req_func != FUNC_ENQ) && hit;

  assign waddr = ADDR_W'(req_target) * ADDR_W'(QUEUE_DEPTH)
               + ADDR_W'(write_pointer[req_target]);
  assign raddr = ADDR_W'(sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(read_pointer[sel]);

  mqws_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (MEM_D)
  ) u_store (
    .clk   (clk),
    .we    (do_enq),
    .waddr (waddr),
    .wdata (req_payload),
    .re    (do_deq),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    total = '0;
    for (int q = 0; q < MAX_QUEUES; q++) begin
      if (q_active[q]) total = total + TOTAL_BITS'(fill_level[q]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_queues <= ACTIVE_RESET;
      steal_order[0] <= ORDER0_RESET;
      steal_order[1] <= ORDER1_RESET;
      steal_order[2] <= ORDER2_RESET;
      steal_order[3] <= ORDER3_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ACTIVE: active_queues  <= cfg_data[ACTIVE_BITS-1:0];
        CFG_ORDER0: steal_order[0] <= cfg_data;
        CFG_ORDER1: steal_order[1] <= cfg_data;
        CFG_ORDER2: steal_order[2] <= cfg_data;
        CFG_ORDER3: steal_order[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < MAX_QUEUES; q++) begin
        read_pointer[q]  <= '0;
        write_pointer[q] <= '0;
        fill_level[q]    <= '0;
      end
    end else begin
      if (do_enq) begin
        write_pointer[req_target] <=
          (write_pointer[req_target] == PTR_W'(QUEUE_DEPTH - 1)) ?
          '0 : write_pointer[req_target] + 1'b1;
        fill_level[req_target] <= fill_level[req_target] + 1'b1;
      end
      if (do_deq) begin
        read_pointer[sel] <= (read_pointer[sel] == PTR_W'(QUEUE_DEPTH - 1)) ?
                             '0 : read_pointer[sel] + 1'b1;
        fill_level[sel] <= fill_level[sel] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_func    <= func_t'(func);
      req_home    <= home_queue;
      req_target  <= target_queue;
      req_payload <= payload_in;
    end
    if (cmd.exec) begin
      res_hit <= (req_func != FUNC_ENQ) && hit;
      res_src <= sel;
      res_ovf <= (req_func == FUNC_ENQ) && !enq_ok;
    end
    if (cmd.load_out) begin
      found        <= res_hit;
      payload_out  <= res_hit ? rdata : '0;
      source_queue <= res_hit ? res_src : '0;
      overflow     <= res_ovf;
      total_items  <= total;
    end
  end

endmodule
`default_nettype wire

>>> rtl/multi_queue_work_stealing_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-queue work-stealing unit
// Per-node bounded FIFOs of work handles with local, stealing and remote
// dequeue modes and a configurable steal order for each node.
// ----------------------------------------------------------------------------
// Each item passes through an execute state, which selects a queue and updates
// its pointers and the item store port, and a wrap state, which loads the
// result and holds while the output is stalled; a new item can be accepted there.
// Reset clears pointers, fill levels and control state, and returns the configuration to its reset values.
// The item store is not cleared; no clearing pass is needed.
module multi_queue_work_stealing_unit
  import mqws_pkg::*;
#(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire [1:0]                 func,
  input  wire [QIDX_BITS-1:0]       home_queue,
  input  wire [QIDX_BITS-1:0]       target_queue,
  input  wire [PAYLOAD_BITS-1:0]    payload_in,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic                      found,
  output logic [PAYLOAD_BITS-1:0]   payload_out,
  output logic [QIDX_BITS-1:0]      source_queue,
  output logic                      overflow,
  output logic [TOTAL_BITS-1:0]     total_items,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire [CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire [CFG_DATA_BITS-1:0]   cfg_data
);

  mqws_cmd_t cmd;

  assign cfg_ready = 1'b1;

  mqws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  mqws_dp #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .func         (func),
    .home_queue   (home_queue),
    .target_queue (target_queue),
    .payload_in   (payload_in),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .found        (found),
    .payload_out  (payload_out),
    .source_queue (source_queue),
    .overflow     (overflow),
    .total_items  (total_items)
  );

endmodule
`default_nettype wire

>>> tb/multi_queue_work_stealing_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multi-queue work-stealing unit testbench
// Drives enqueue and the three dequeue modes through the item port and checks
// every result against an in-bench model of the per-node queues, the first
// directed items against their table rows. The run goes through a short table
// of directed items, then phases of random traffic under different queue
// counts and steal orders, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module multi_queue_work_stealing_unit_tb;
  import mqws_pkg::*;

  localparam int NQ    = NUM_QUEUES_DEF;
  localparam int DEPTH = QUEUE_DEPTH_DEF;

  typedef struct packed {
    logic                    found;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [QIDX_BITS-1:0]    source;
    logic                    overflow;
    logic [TOTAL_BITS-1:0]   total;
  } work_result_t;

  typedef struct {
    func_t                   op;
    logic [QIDX_BITS-1:0]    home;
    logic [QIDX_BITS-1:0]    target;
    logic [PAYLOAD_BITS-1:0] data;
    bit                      typed;
    work_result_t            want;
  } work_req_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                func = '0;
  logic [QIDX_BITS-1:0]      home_queue = '0;
  logic [QIDX_BITS-1:0]      target_queue = '0;
  logic [PAYLOAD_BITS-1:0]   payload_in = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      found;
  logic [PAYLOAD_BITS-1:0]   payload_out;
  logic [QIDX_BITS-1:0]      source_queue;
  logic                      overflow;
  logic [TOTAL_BITS-1:0]     total_items;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  // Model of the queues and of the configuration.
  logic [PAYLOAD_BITS-1:0] held_items [NQ][DEPTH];
  int                      head_ptr [NQ];
  int                      tail_ptr [NQ];
  int                      depth_used [NQ];
  logic [ACTIVE_BITS-1:0]  live_count;
  logic [ORDER_BITS-1:0]   steal_order [4];

  work_result_t expected_results [$];
  work_req_t    offered_reqs [$];
  work_req_t    directed_rows [$];

  int errors = 0;
  int items_accepted = 0;
  int handles_found = 0;
  int drops = 0;
  int peak_total = 0;
  int settings_used = 1;
  int burst_left = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  multi_queue_work_stealing_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .home_queue   (home_queue),
    .target_queue (target_queue),
    .payload_in   (payload_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .payload_out  (payload_out),
    .source_queue (source_queue),
    .overflow     (overflow),
    .total_items  (total_items),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit queue_live(input int q);
    int lim;
    lim = (live_count > NQ) ? NQ : int'(live_count);
    return q < lim;
  endfunction

  function automatic bit take_from(input int q, output logic [PAYLOAD_BITS-1:0] val);
    val = '0;
    if (!queue_live(q) || depth_used[q] == 0) return 1'b0;
    val = held_items[q][head_ptr[q]];
    head_ptr[q] = (head_ptr[q] + 1) % DEPTH;
    depth_used[q]--;
    return 1'b1;
  endfunction

  function automatic bit steal_for(input logic [QIDX_BITS-1:0] home,
                                   output logic [PAYLOAD_BITS-1:0] val, output int src);
    int q;
    src = 0;
    val = '0;
    for (int k = 0; k < 3; k++) begin
      q = steal_order[home][2*k +: 2];
      if (take_from(q, val)) begin
        src = q;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic work_result_t apply_queue_op(input func_t op,
      input logic [QIDX_BITS-1:0] home, input logic [QIDX_BITS-1:0] target,
      input logic [PAYLOAD_BITS-1:0] data);
    work_result_t r;
    logic [PAYLOAD_BITS-1:0] val;
    int src;
    bit got;
    int sum;
    r = '0;
    val = '0;
    src = 0;
    got = 1'b0;
    sum = 0;
    case (op)
      FUNC_ENQ: begin
        if (!queue_live(target) || depth_used[target] >= DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          held_items[target][tail_ptr[target]] = data;
          tail_ptr[target] = (tail_ptr[target] + 1) % DEPTH;
          depth_used[target]++;
        end
      end
      FUNC_STEAL: begin
        got = take_from(home, val);
        src = home;
        if (!got) got = steal_for(home, val, src);
      end
      FUNC_LOCAL: begin
        got = take_from(home, val);
        src = home;
      end
      default: begin
        got = steal_for(home, val, src);
        if (!got) begin
          got = take_from(home, val);
          src = home;
        end
      end
    endcase
    if (got) begin
      r.found = 1'b1;
      r.payload = val;
      r.source = src[QIDX_BITS-1:0];
    end
    for (int q = 0; q < NQ; q++) begin
      if (queue_live(q)) sum += depth_used[q];
    end
    r.total = sum[TOTAL_BITS-1:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  function automatic work_req_t row(input func_t op, input logic [1:0] home,
      input logic [1:0] target, input logic [31:0] data, input bit typed,
      input logic f, input logic [31:0] p, input logic [1:0] s, input logic o,
      input logic [8:0] t);
    work_req_t r;
    r.op = op;
    r.home = home;
    r.target = target;
    r.data = data;
    r.typed = typed;
    r.want.found = f;
    r.want.payload = p;
    r.want.source = s;
    r.want.overflow = o;
    r.want.total = t;
    return r;
  endfunction

  function automatic work_req_t random_req(input int enq_pct);
    work_req_t r;
    r = row(FUNC_ENQ, 2'($urandom), 2'($urandom), $urandom, 1'b0, 0, 0, 0, 0, 0);
    if ($urandom_range(0, 99) >= enq_pct) r.op = func_t'($urandom_range(1, 3));
    case ($urandom_range(0, 7))
      0: r.data = '0;
      1: r.data = '1;
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    work_result_t got;
    work_result_t want;
    work_req_t req;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.found = found;
        got.payload = payload_out;
        got.source = source_queue;
        got.overflow = overflow;
        got.total = total_items;
        if (got.found) handles_found++;
        if (got.overflow) drops++;
        if (int'(got.total) > peak_total) peak_total = got.total;
        if (expected_results.size() == 0) begin
          errors++;
          $error("result arrived with no item outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("found", want.found, got.found);
          check_field("payload_out", want.payload, got.payload);
          check_field("source_queue", want.source, got.source);
          check_field("overflow", want.overflow, got.overflow);
          check_field("total_items", want.total, got.total);
        end
      end
      if (in_valid && !in_stall) begin
        items_accepted++;
        req = offered_reqs.pop_front();
        want = apply_queue_op(func_t'(func), home_queue, target_queue, payload_in);
        if (req.typed) want = req.want;
        expected_results.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    if (holds_done != hold_requests) begin
      holds_done++;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= !out_stall;
      endcase
    end
  end

  task automatic send_item(input work_req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    offered_reqs.push_back(r);
    in_valid <= 1'b1;
    func <= r.op;
    home_queue <= r.home;
    target_queue <= r.target;
    payload_in <= r.data;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ACTIVE: live_count = val[ACTIVE_BITS-1:0];
      CFG_ORDER0: steal_order[0] = val;
      CFG_ORDER1: steal_order[1] = val;
      CFG_ORDER2: steal_order[2] = val;
      CFG_ORDER3: steal_order[3] = val;
      default: ;
    endcase
  endtask

  initial begin
    #8_000_000;
    $display("[multi_queue_work_stealing_unit] ERROR");
    $finish;
  end

  initial begin
    int phase_active [10] = '{4, 4, 4, 1, 2, 0, 7, 3, 5, 4};
    int phase_enq [10]    = '{60, 95, 10, 80, 50, 50, 50, 40, 30, 20};
    int phase_items [10]  = '{150, 300, 300, 150, 150, 100, 200, 200, 200, 250};
    logic [CFG_INDEX_BITS-1:0] order_regs [4] = '{CFG_ORDER0, CFG_ORDER1, CFG_ORDER2,
                                                  CFG_ORDER3};
    logic [ORDER_BITS-1:0] order_resets [4] = '{ORDER0_RESET, ORDER1_RESET, ORDER2_RESET,
                                                ORDER3_RESET};
    logic [ORDER_BITS-1:0] ord;

    for (int q = 0; q < NQ; q++) begin
      head_ptr[q] = 0;
      tail_ptr[q] = 0;
      depth_used[q] = 0;
    end
    live_count = ACTIVE_RESET;
    for (int n = 0; n < 4; n++) steal_order[n] = order_resets[n];

    // Empty queues first, then one handle per node, then local, stealing and
    // remote dequeues, mixed with further enqueues, against the reset steal orders.
    directed_rows.push_back(row(FUNC_LOCAL,  0, 0, 32'h0,        1, 0, 32'h0,        0, 0, 0));
    directed_rows.push_back(row(FUNC_STEAL,  3, 0, 32'h0,        1, 0, 32'h0,        0, 0, 0));
    directed_rows.push_back(row(FUNC_REMOTE, 1, 0, 32'h0,        1, 0, 32'h0,        0, 0, 0));
    directed_rows.push_back(row(FUNC_ENQ,    0, 0, 32'hFFFFFFFF, 1, 0, 32'h0,        0, 0, 1));
    directed_rows.push_back(row(FUNC_ENQ,    0, 3, 32'h00000000, 1, 0, 32'h0,        0, 0, 2));
    directed_rows.push_back(row(FUNC_ENQ,    0, 1, 32'hAAAAAAAA, 1, 0, 32'h0,        0, 0, 3));
    directed_rows.push_back(row(FUNC_ENQ,    0, 2, 32'h55555555, 1, 0, 32'h0,        0, 0, 4));
    directed_rows.push_back(row(FUNC_LOCAL,  0, 0, 32'h0,        1, 1, 32'hFFFFFFFF, 0, 0, 3));
    directed_rows.push_back(row(FUNC_LOCAL,  0, 0, 32'h0,        1, 0, 32'h0,        0, 0, 3));
    directed_rows.push_back(row(FUNC_STEAL,  0, 0, 32'h0,        0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(FUNC_REMOTE, 3, 0, 32'h0,        0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(FUNC_REMOTE, 3, 0, 32'h0,        0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(FUNC_STEAL,  2, 0, 32'h0,        0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(FUNC_ENQ,    1, 2, 32'h12345678, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(FUNC_ENQ,    3, 2, 32'h87654321, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(FUNC_STEAL,  2, 1, 32'h0,        0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(FUNC_REMOTE, 2, 3, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(FUNC_ENQ,    2, 1, 32'hDEADBEEF, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(FUNC_REMOTE, 1, 0, 32'h0,        0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(FUNC_ENQ,    0, 0, 32'h00000001, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(FUNC_ENQ,    0, 0, 32'h80000000, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(FUNC_LOCAL,  0, 2, 32'h0,        0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(FUNC_STEAL,  1, 0, 32'h0,        0, 0, 0, 0, 0, 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) send_item(directed_rows[i]);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      write_register(CFG_ACTIVE, {3'($urandom), 3'(phase_active[p])});
      for (int n = 0; n < 4; n++) begin
        case (p)
          0: ord = order_resets[n];
          3: ord = '0;
          4: ord = '1;
          default: ord = 6'($urandom_range(0, 63));
        endcase
        write_register(order_regs[n], ord);
      end
      cfg_valid <= 1'b0;
      settings_used++;
      if (p == 1) hold_requests++;
      for (int i = 0; i < phase_items[p]; i++) begin
        if (p == 2 && i == phase_items[p] / 2) wait_drained();
        send_item(random_req(phase_enq[p]));
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("Run covered %0d items under %0d register settings.",
             items_accepted, settings_used);
    $display("%0d dequeues returned a handle, %0d enqueues were dropped, peak occupancy %0d.",
             handles_found, drops, peak_total);
    if (errors == 0) begin
      $display("[multi_queue_work_stealing_unit] OK");
    end else begin
      $display("[multi_queue_work_stealing_unit] ERROR");
    end
    $finish;
  end

endmodule
